### sv/nearest_point_match_2d_core_macros.svh
// Assertion macros for the nearest point match core.
// Used by the checker module; depends on clk and rst_n in the enclosing scope.
`ifndef NEAREST_POINT_MATCH_2D_CORE_MACROS_SVH
`define NEAREST_POINT_MATCH_2D_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NPM2D_ASSERT_NOW(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NPM2D_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

### sv/npm2d_pkg.sv
// Shared constants, codes and types of the nearest point match core.
// No dependencies; imported by every module of the core.
package npm2d_pkg;

    localparam int NPM_MAX_POINTS = 1024;
    localparam int NPM_CNT_W      = 11;
    localparam int NPM_COORD_W    = 16;
    localparam int NPM_OPND_W     = 17;
    localparam int NPM_PROD_W     = 34;
    localparam int NPM_DIST_W     = 33;
    localparam int NPM_IDX_W      = 10;
    localparam int NPM_CFG_IDX_W  = 3;
    localparam int NPM_POINT_W    = 32;

    localparam logic signed [NPM_COORD_W-1:0] NPM_ROT_ONE = 16'sd16384;

    typedef enum logic [NPM_CFG_IDX_W-1:0] {
        CFG_ROT_XX,
        CFG_ROT_XY,
        CFG_ROT_YX,
        CFG_ROT_YY,
        CFG_SHIFT_X,
        CFG_SHIFT_Y,
        CFG_TARGET_COUNT
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROT_X,
        ST_ROT_Y,
        ST_ROT_END,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        OP_ROT_X,
        OP_ROT_Y,
        OP_DIST
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic                 busy;
        logic                 cap_q;
        logic                 cap_mx;
        logic                 cap_my;
        logic                 rd_en;
        logic [NPM_CNT_W-1:0] rd_idx;
        logic                 cmp_en;
        logic [NPM_CNT_W-1:0] cmp_idx;
        logic                 load_out;
    } seq_ctrl_t;

    typedef struct packed {
        logic signed [NPM_OPND_W-1:0] a0;
        logic signed [NPM_OPND_W-1:0] b0;
        logic signed [NPM_OPND_W-1:0] a1;
        logic signed [NPM_OPND_W-1:0] b1;
    } mul_req_t;

endpackage

### sv/nearest_point_match_2d_core.sv
// Top level of the nearest point match core: ports, registers and datapath.
// Depends on npm2d_pkg, npm2d_mem, npm2d_mul and npm2d_seq.
//
// Channel | Handshake           | Contents
// in      | in_valid / in_stall | mode, slot, px, py (load target or query)
// out     | out_valid/out_stall | moved_x/y, match_x/y, match_index, dist_sq, found
// cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data (register writes)
//
// A query first passes through the transform steps; an empty search then goes straight
// to the result, any other does one distance compare per cycle on the single read port
// of the target RAM. The input is free again once the result enters the output register.
// Reset sets the identity transform and an empty search; the table is undefined until loaded.
// A finished result waits in the output register; loads and the next query are taken
// meanwhile, and that query completes once the output register is free.
module nearest_point_match_2d_core
    import npm2d_pkg::*;
#(
    parameter int MAX_POINTS = NPM_MAX_POINTS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic [NPM_IDX_W-1:0]          slot,
    input  logic signed [NPM_COORD_W-1:0] px,
    input  logic signed [NPM_COORD_W-1:0] py,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [NPM_COORD_W-1:0] moved_x,
    output logic signed [NPM_COORD_W-1:0] moved_y,
    output logic signed [NPM_COORD_W-1:0] match_x,
    output logic signed [NPM_COORD_W-1:0] match_y,
    output logic [NPM_IDX_W-1:0]          match_index,
    output logic [NPM_DIST_W-1:0]         dist_sq,
    output logic                          found,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [NPM_CFG_IDX_W-1:0]      cfg_index,
    input  logic [NPM_COORD_W-1:0]        cfg_data
);

    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    seq_ctrl_t ctrl;
    mul_req_t  mul_req;

    logic signed [NPM_COORD_W-1:0] rot_xx_reg;
    logic signed [NPM_COORD_W-1:0] rot_xy_reg;
    logic signed [NPM_COORD_W-1:0] rot_yx_reg;
    logic signed [NPM_COORD_W-1:0] rot_yy_reg;
    logic signed [NPM_COORD_W-1:0] shift_x_reg;
    logic signed [NPM_COORD_W-1:0] shift_y_reg;
    logic [NPM_CNT_W-1:0]          target_count_reg;
    logic [NPM_CNT_W-1:0]          eff_cnt;

    logic                   in_accept;
    logic                   load_wr;
    logic [NPM_POINT_W-1:0] rd_data;

    logic signed [NPM_COORD_W-1:0] qx_reg;
    logic signed [NPM_COORD_W-1:0] qy_reg;
    logic signed [NPM_COORD_W-1:0] mx_reg;
    logic signed [NPM_COORD_W-1:0] my_reg;
    logic signed [NPM_PROD_W-1:0]  mul_p0;
    logic signed [NPM_PROD_W-1:0]  mul_p1;

    logic signed [NPM_COORD_W-1:0] tx_s1;
    logic signed [NPM_COORD_W-1:0] ty_s1;
    logic signed [NPM_COORD_W-1:0] tx_s2_reg;
    logic signed [NPM_COORD_W-1:0] ty_s2_reg;
    logic signed [NPM_OPND_W-1:0]  dx;
    logic signed [NPM_OPND_W-1:0]  dy;

    logic signed [NPM_PROD_W-1:0]  axis_acc;
    logic signed [19:0]            axis_floor;
    logic signed [19:0]            axis_sum;
    logic signed [NPM_COORD_W-1:0] axis_shift;
    logic signed [NPM_COORD_W-1:0] axis_sat;
    logic [NPM_DIST_W-1:0]         dist_now;

    logic                          best_found_reg;
    logic [NPM_DIST_W-1:0]         best_d_reg;
    logic [NPM_IDX_W-1:0]          best_idx_reg;
    logic signed [NPM_COORD_W-1:0] best_x_reg;
    logic signed [NPM_COORD_W-1:0] best_y_reg;
    logic                          best_take;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          out_free;
    logic signed [NPM_COORD_W-1:0] moved_x_reg;
    logic signed [NPM_COORD_W-1:0] moved_y_reg;
    logic signed [NPM_COORD_W-1:0] match_x_reg;
    logic signed [NPM_COORD_W-1:0] match_y_reg;
    logic [NPM_IDX_W-1:0]          match_index_reg;
    logic [NPM_DIST_W-1:0]         dist_sq_reg;
    logic                          found_reg;

    assign cfg_ready = 1'b1;
    assign in_stall  = ctrl.busy;
    assign in_accept = in_valid && !in_stall;
    assign load_wr   = in_accept && !mode && ({22'd0, slot} < 32'(MAX_POINTS));
    assign out_free  = !out_valid_reg || !out_stall;

    assign eff_cnt = ({21'd0, target_count_reg} > 32'(MAX_POINTS)) ?
                     NPM_CNT_W'(MAX_POINTS) : target_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_xx_reg       <= NPM_ROT_ONE;
            rot_xy_reg       <= '0;
            rot_yx_reg       <= '0;
            rot_yy_reg       <= NPM_ROT_ONE;
            shift_x_reg      <= '0;
            shift_y_reg      <= '0;
            target_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_ROT_XX:       rot_xx_reg       <= cfg_data;
                CFG_ROT_XY:       rot_xy_reg       <= cfg_data;
                CFG_ROT_YX:       rot_yx_reg       <= cfg_data;
                CFG_ROT_YY:       rot_yy_reg       <= cfg_data;
                CFG_SHIFT_X:      shift_x_reg      <= cfg_data;
                CFG_SHIFT_Y:      shift_y_reg      <= cfg_data;
                CFG_TARGET_COUNT: target_count_reg <= cfg_data[NPM_CNT_W-1:0];
                default:          target_count_reg <= target_count_reg;
            endcase
        end
    end

    npm2d_seq u_seq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .query_valid (in_valid && mode),
        .cnt         (eff_cnt),
        .out_free    (out_free),
        .ctrl        (ctrl)
    );

    npm2d_mem #(
        .DEPTH (MAX_POINTS)
    ) u_mem
    (
        .clk         (clk),
        .wr_en       (load_wr),
        .wr_addr     (ADDR_W'(slot)),
        .wr_data     ({py, px}),
        .rd_en       (ctrl.rd_en),
        .rd_addr     (ADDR_W'(ctrl.rd_idx)),
        .rd_data_reg (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.cap_q)
        begin
            qx_reg <= px;
            qy_reg <= py;
        end
    end

    assign tx_s1 = rd_data[NPM_COORD_W-1:0];
    assign ty_s1 = rd_data[NPM_POINT_W-1:NPM_COORD_W];
    assign dx    = NPM_OPND_W'(mx_reg) - NPM_OPND_W'(tx_s1);
    assign dy    = NPM_OPND_W'(my_reg) - NPM_OPND_W'(ty_s1);

    always_comb
    begin
        case (ctrl.op)
            OP_ROT_X:
            begin
                mul_req.a0 = NPM_OPND_W'(rot_xx_reg);
                mul_req.b0 = NPM_OPND_W'(qx_reg);
                mul_req.a1 = NPM_OPND_W'(rot_xy_reg);
                mul_req.b1 = NPM_OPND_W'(qy_reg);
            end
            OP_ROT_Y:
            begin
                mul_req.a0 = NPM_OPND_W'(rot_yx_reg);
                mul_req.b0 = NPM_OPND_W'(qx_reg);
                mul_req.a1 = NPM_OPND_W'(rot_yy_reg);
                mul_req.b1 = NPM_OPND_W'(qy_reg);
            end
            default:
            begin
                mul_req.a0 = dx;
                mul_req.b0 = dx;
                mul_req.a1 = dy;
                mul_req.b1 = dy;
            end
        endcase
    end

    npm2d_mul u_mul
    (
        .clk    (clk),
        .req    (mul_req),
        .p0_reg (mul_p0),
        .p1_reg (mul_p1)
    );

    always_comb
    begin
        axis_acc   = mul_p0 + mul_p1;
        axis_floor = axis_acc[NPM_PROD_W-1:14];
        axis_shift = ctrl.cap_mx ? shift_x_reg : shift_y_reg;
        axis_sum   = axis_floor + 20'(axis_shift);
        if (axis_sum > 20'sd32767)
        begin
            axis_sat = 16'sh7FFF;
        end
        else if (axis_sum < -20'sd32768)
        begin
            axis_sat = 16'sh8000;
        end
        else
        begin
            axis_sat = axis_sum[NPM_COORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.cap_mx)
        begin
            mx_reg <= axis_sat;
        end
        if (ctrl.cap_my)
        begin
            my_reg <= axis_sat;
        end
        tx_s2_reg <= tx_s1;
        ty_s2_reg <= ty_s1;
    end

    assign dist_now  = {1'b0, mul_p0[31:0]} + {1'b0, mul_p1[31:0]};
    assign best_take = ctrl.cmp_en && (!best_found_reg || (dist_now < best_d_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_found_reg <= 1'b0;
            best_d_reg     <= '0;
            best_idx_reg   <= '0;
            best_x_reg     <= '0;
            best_y_reg     <= '0;
        end
        else if (ctrl.cap_q)
        begin
            best_found_reg <= 1'b0;
            best_d_reg     <= '0;
            best_idx_reg   <= '0;
            best_x_reg     <= '0;
            best_y_reg     <= '0;
        end
        else if (best_take)
        begin
            best_found_reg <= 1'b1;
            best_d_reg     <= dist_now;
            best_idx_reg   <= ctrl.cmp_idx[NPM_IDX_W-1:0];
            best_x_reg     <= tx_s2_reg;
            best_y_reg     <= ty_s2_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            moved_x_reg     <= mx_reg;
            moved_y_reg     <= my_reg;
            match_x_reg     <= best_x_reg;
            match_y_reg     <= best_y_reg;
            match_index_reg <= best_idx_reg;
            dist_sq_reg     <= best_d_reg;
            found_reg       <= best_found_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign moved_x     = moved_x_reg;
    assign moved_y     = moved_y_reg;
    assign match_x     = match_x_reg;
    assign match_y     = match_y_reg;
    assign match_index = match_index_reg;
    assign dist_sq     = dist_sq_reg;
    assign found       = found_reg;

endmodule

### sv/npm2d_mem.sv
// Target point RAM: one write port and one registered read port.
// Depends on npm2d_pkg for the default depth and the point width.
module npm2d_mem
    import npm2d_pkg::*;
#(
    parameter int   DEPTH  = NPM_MAX_POINTS,
    localparam int  ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [ADDR_W-1:0]      wr_addr,
    input  logic [NPM_POINT_W-1:0] wr_data,
    input  logic                   rd_en,
    input  logic [ADDR_W-1:0]      rd_addr,
    output logic [NPM_POINT_W-1:0] rd_data_reg
);

    logic [NPM_POINT_W-1:0] points_reg [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            points_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= points_reg[rd_addr];
        end
    end

endmodule

### sv/npm2d_mul.sv
// Shared dual multiplier used for the rotation and for the squared distances.
// Depends on npm2d_pkg for the operand and product widths.
module npm2d_mul
    import npm2d_pkg::*;
(
    input  logic                         clk,
    input  mul_req_t                     req,
    output logic signed [NPM_PROD_W-1:0] p0_reg,
    output logic signed [NPM_PROD_W-1:0] p1_reg
);

    logic signed [NPM_PROD_W-1:0] p0_next;
    logic signed [NPM_PROD_W-1:0] p1_next;

    always_comb
    begin
        p0_next = req.a0 * req.b0;
        p1_next = req.a1 * req.b1;
    end

    always_ff @(posedge clk)
    begin
        p0_reg <= p0_next;
        p1_reg <= p1_next;
    end

endmodule

### sv/npm2d_seq.sv
// Sequencer of the core: transform steps, table scan and result hand-off.
// Depends on npm2d_pkg for the state, operation and control types.
module npm2d_seq
    import npm2d_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 query_valid,
    input  logic [NPM_CNT_W-1:0] cnt,
    input  logic                 out_free,
    output seq_ctrl_t            ctrl
);

    state_t               state_reg;
    state_t               state_next;
    logic [NPM_CNT_W-1:0] idx_reg;
    logic [NPM_CNT_W-1:0] idx_next;
    logic [NPM_CNT_W-1:0] idx_s1_reg;
    logic [NPM_CNT_W-1:0] idx_s2_reg;
    logic                 s1_reg;
    logic                 s2_reg;
    logic [NPM_CNT_W-1:0] last_idx;

    assign last_idx = cnt - NPM_CNT_W'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (query_valid)
                begin
                    state_next = ST_ROT_X;
                end
            end
            ST_ROT_X:
            begin
                state_next = ST_ROT_Y;
            end
            ST_ROT_Y:
            begin
                state_next = ST_ROT_END;
            end
            ST_ROT_END:
            begin
                state_next = (cnt == '0) ? ST_FINISH : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (idx_reg == last_idx)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_reg && !s2_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl         = '0;
        ctrl.op      = OP_DIST;
        ctrl.busy    = (state_reg != ST_IDLE);
        ctrl.rd_idx  = idx_reg;
        ctrl.cmp_en  = s2_reg;
        ctrl.cmp_idx = idx_s2_reg;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.cap_q = query_valid;
            end
            ST_ROT_X:
            begin
                ctrl.op = OP_ROT_X;
            end
            ST_ROT_Y:
            begin
                ctrl.op     = OP_ROT_Y;
                ctrl.cap_mx = 1'b1;
            end
            ST_ROT_END:
            begin
                ctrl.cap_my = 1'b1;
            end
            ST_SCAN:
            begin
                ctrl.rd_en = 1'b1;
            end
            ST_DRAIN:
            begin
                ctrl.rd_en = 1'b0;
            end
            ST_FINISH:
            begin
                ctrl.load_out = out_free;
            end
            default:
            begin
                ctrl.rd_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        idx_next = (state_reg == ST_SCAN) ? idx_reg + NPM_CNT_W'(1) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            s1_reg     <= 1'b0;
            s2_reg     <= 1'b0;
            idx_s1_reg <= '0;
            idx_s2_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            s1_reg     <= ctrl.rd_en;
            s2_reg     <= s1_reg;
            idx_s1_reg <= idx_reg;
            idx_s2_reg <= idx_s1_reg;
        end
    end

endmodule

### sv/npm2d_chk.sv
// Port-level checker of the nearest point match core and its bind statement.
// Depends on nearest_point_match_2d_core_macros.svh and the core's port list.
`include "nearest_point_match_2d_core_macros.svh"

module npm2d_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        mode,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] moved_x,
    input logic [15:0] moved_y,
    input logic [15:0] match_x,
    input logic [15:0] match_y,
    input logic [9:0]  match_index,
    input logic [32:0] dist_sq,
    input logic        found
);

    // A stalled result transaction stays offered.
    `NPM2D_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

    // A stalled result transaction keeps its moved point, distance and found flag.
    `NPM2D_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(moved_x) && $stable(moved_y) && $stable(dist_sq) && $stable(found), "result payload changed while stalled")

    // An empty search reports a zero match.
    `NPM2D_ASSERT_NOW(a_empty_zero, out_valid && !found, dist_sq == 33'd0 && match_index == 10'd0 && match_x == 16'd0 && match_y == 16'd0, "empty search with nonzero match")

    // A query occupies the block in the following cycle.
    `NPM2D_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && mode, in_stall, "query accepted without becoming busy")

endmodule

bind nearest_point_match_2d_core npm2d_chk u_npm2d_chk (.*);

### bench/npm2d_match_checker.sv
// Checker for the nearest point match core: follows the load/query, result and register
// write channels, predicts every query result and compares it field by field.
// Depends on npm2d_pkg; instantiated beside the core by tb_nearest_point_match_2d_core.
module npm2d_match_checker
    import npm2d_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          mode,
    input  logic [NPM_IDX_W-1:0]          slot,
    input  logic signed [NPM_COORD_W-1:0] px,
    input  logic signed [NPM_COORD_W-1:0] py,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic signed [NPM_COORD_W-1:0] moved_x,
    input  logic signed [NPM_COORD_W-1:0] moved_y,
    input  logic signed [NPM_COORD_W-1:0] match_x,
    input  logic signed [NPM_COORD_W-1:0] match_y,
    input  logic [NPM_IDX_W-1:0]          match_index,
    input  logic [NPM_DIST_W-1:0]         dist_sq,
    input  logic                          found,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [NPM_CFG_IDX_W-1:0]      cfg_index,
    input  logic [NPM_COORD_W-1:0]        cfg_data,
    output int                            fail_count,
    output int                            waiting,
    output int                            checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [NPM_COORD_W-1:0] moved_x;
        logic signed [NPM_COORD_W-1:0] moved_y;
        logic signed [NPM_COORD_W-1:0] match_x;
        logic signed [NPM_COORD_W-1:0] match_y;
        logic [NPM_IDX_W-1:0]          match_index;
        logic [NPM_DIST_W-1:0]         dist_sq;
        logic                          found;
    } match_result_t;

    logic signed [NPM_COORD_W-1:0] rot_xx;
    logic signed [NPM_COORD_W-1:0] rot_xy;
    logic signed [NPM_COORD_W-1:0] rot_yx;
    logic signed [NPM_COORD_W-1:0] rot_yy;
    logic signed [NPM_COORD_W-1:0] shift_x;
    logic signed [NPM_COORD_W-1:0] shift_y;
    logic [NPM_CNT_W-1:0]          target_count;
    logic [NPM_POINT_W-1:0]        targets [NPM_MAX_POINTS];
    match_result_t                 pending_matches [$];

    function automatic logic signed [NPM_COORD_W-1:0] transform_axis(
        input logic signed [NPM_COORD_W-1:0] ra,
        input logic signed [NPM_COORD_W-1:0] rb,
        input logic signed [NPM_COORD_W-1:0] sh,
        input logic signed [NPM_COORD_W-1:0] x,
        input logic signed [NPM_COORD_W-1:0] y
    );
        longint acc;
        acc = (longint'(ra) * longint'(x) + longint'(rb) * longint'(y)) >>> 14;
        acc = acc + longint'(sh);
        if (acc > 32767)
            acc = 32767;
        else if (acc < -32768)
            acc = -32768;
        return acc[NPM_COORD_W-1:0];
    endfunction

    function automatic match_result_t search_nearest(
        input logic signed [NPM_COORD_W-1:0] qx,
        input logic signed [NPM_COORD_W-1:0] qy
    );
        match_result_t                 r;
        int                            n;
        longint                        dx;
        longint                        dy;
        longint                        d;
        logic signed [NPM_COORD_W-1:0] tx;
        logic signed [NPM_COORD_W-1:0] ty;
        r.moved_x     = transform_axis(rot_xx, rot_xy, shift_x, qx, qy);
        r.moved_y     = transform_axis(rot_yx, rot_yy, shift_y, qx, qy);
        r.match_x     = '0;
        r.match_y     = '0;
        r.match_index = '0;
        r.dist_sq     = '0;
        r.found       = 1'b0;
        n = (target_count > NPM_MAX_POINTS) ? NPM_MAX_POINTS : int'(target_count);
        for (int j = 0; j < n; j++)
        begin
            tx = targets[j][NPM_COORD_W-1:0];
            ty = targets[j][NPM_POINT_W-1:NPM_COORD_W];
            dx = longint'(r.moved_x) - longint'(tx);
            dy = longint'(r.moved_y) - longint'(ty);
            d  = dx * dx + dy * dy;
            if (!r.found || d < r.dist_sq)
            begin
                r.found       = 1'b1;
                r.dist_sq     = d[NPM_DIST_W-1:0];
                r.match_index = j[NPM_IDX_W-1:0];
                r.match_x     = tx;
                r.match_y     = ty;
            end
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        match_result_t head;
        if (!rst_n)
        begin
            rot_xx       = NPM_ROT_ONE;
            rot_xy       = '0;
            rot_yx       = '0;
            rot_yy       = NPM_ROT_ONE;
            shift_x      = '0;
            shift_y      = '0;
            target_count = '0;
            pending_matches.delete();
            fail_count   = 0;
            waiting      = 0;
            checked      = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_matches.size() == 0)
                begin
                    $error("Result transaction arrived with no query outstanding");
                    fail_count++;
                end
                else
                begin
                    head = pending_matches.pop_front();
                    compare_field("moved_x", head.moved_x, moved_x);
                    compare_field("moved_y", head.moved_y, moved_y);
                    compare_field("match_x", head.match_x, match_x);
                    compare_field("match_y", head.match_y, match_y);
                    compare_field("match_index", head.match_index, match_index);
                    compare_field("dist_sq", head.dist_sq, dist_sq);
                    compare_field("found", head.found, found);
                    checked++;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ROT_XX:       rot_xx = cfg_data;
                    CFG_ROT_XY:       rot_xy = cfg_data;
                    CFG_ROT_YX:       rot_yx = cfg_data;
                    CFG_ROT_YY:       rot_yy = cfg_data;
                    CFG_SHIFT_X:      shift_x = cfg_data;
                    CFG_SHIFT_Y:      shift_y = cfg_data;
                    CFG_TARGET_COUNT: target_count = cfg_data[NPM_CNT_W-1:0];
                    default:          ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (mode == 1'b0)
                    targets[slot] = {py, px};
                else
                    pending_matches.insert(pending_matches.size(), search_nearest(px, py));
            end
            waiting = pending_matches.size();
        end
    end

endmodule

### bench/tb_nearest_point_match_2d_core.sv
// Testbench top for the nearest point match core: clock, reset, target loads, queries
// and register writes with random gaps and output stalls; npm2d_match_checker checks.
// Depends on npm2d_pkg, nearest_point_match_2d_core and npm2d_match_checker.
module tb_nearest_point_match_2d_core
    import npm2d_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_BUDGET   = 580;
    localparam int SETTLE_CYCLES = 16;
    localparam int END_CYCLES    = 32;
    localparam int COUNT_ALL_ONES = (1 << NPM_CNT_W) - 1;
    localparam logic [NPM_CFG_IDX_W-1:0] CFG_SPARE_INDEX = 3'd7;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic                          mode;
    logic [NPM_IDX_W-1:0]          slot;
    logic signed [NPM_COORD_W-1:0] px;
    logic signed [NPM_COORD_W-1:0] py;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [NPM_COORD_W-1:0] moved_x;
    logic signed [NPM_COORD_W-1:0] moved_y;
    logic signed [NPM_COORD_W-1:0] match_x;
    logic signed [NPM_COORD_W-1:0] match_y;
    logic [NPM_IDX_W-1:0]          match_index;
    logic [NPM_DIST_W-1:0]         dist_sq;
    logic                          found;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [NPM_CFG_IDX_W-1:0]      cfg_index;
    logic [NPM_COORD_W-1:0]        cfg_data;
    int                            fail_count;
    int                            waiting;
    int                            checked;

    bit in_quiet;
    bit out_quiet;
    bit loaded [NPM_MAX_POINTS];
    int coord_span = 4;
    int n_loads;
    int n_queries;
    int n_settings;

    nearest_point_match_2d_core u_top (.*);

    npm2d_match_checker u_checker (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : result_stall
        int n;
        out_stall = 1'b0;
        @(negedge clk);
        forever
        begin
            n = out_quiet ? 0 : $urandom_range(0, 13);
            if (n > 0)
            begin
                out_stall = 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    function automatic logic [NPM_COORD_W-1:0] pick_coord();
        int k;
        k = $urandom_range(0, 9);
        if (k < 5)
            return 16'($urandom_range(0, 2 * coord_span) - coord_span);
        if (k < 9)
            return 16'($urandom);
        case ($urandom_range(0, 3))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    function automatic logic [NPM_COORD_W-1:0] pick_rot();
        case ($urandom_range(0, 5))
            0:       return NPM_ROT_ONE;
            1:       return 16'(-NPM_ROT_ONE);
            2:       return 16'h0000;
            3:       return 16'(NPM_ROT_ONE + $urandom_range(0, 512) - 256);
            4:       return 16'($urandom);
            default: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        endcase
    endfunction

    task automatic push_item(input logic m, input logic [NPM_IDX_W-1:0] s,
                             input logic [NPM_COORD_W-1:0] x, input logic [NPM_COORD_W-1:0] y);
        int gap;
        gap = in_quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        mode     = m;
        slot     = s;
        px       = x;
        py       = y;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic load_target(input int s, input logic [NPM_COORD_W-1:0] x,
                               input logic [NPM_COORD_W-1:0] y);
        push_item(1'b0, s[NPM_IDX_W-1:0], x, y);
        loaded[s] = 1'b1;
        n_loads++;
    endtask

    task automatic ask(input logic [NPM_COORD_W-1:0] x, input logic [NPM_COORD_W-1:0] y);
        push_item(1'b1, 10'($urandom_range(0, NPM_MAX_POINTS - 1)), x, y);
        n_queries++;
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (waiting != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [NPM_CFG_IDX_W-1:0] r, input logic [NPM_COORD_W-1:0] v);
        cfg_valid = 1'b1;
        cfg_index = r;
        cfg_data  = v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin : stimulus
        int  random_items;
        int  cur_count;
        int  hi_slot;
        int  phase_len;
        int  roll;
        bit  plain;
        bit  big_done;
        in_valid  = 1'b0;
        mode      = 1'b0;
        slot      = '0;
        px        = '0;
        py        = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_quiet  = 1'b0;
        out_quiet = 1'b0;
        random_items = 0;
        big_done  = 1'b0;
        rst_n     = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset state: identity transform and an empty search.
        ask(16'sd1000, -16'sd2000);
        load_target(0, 16'h7FFF, 16'h7FFF);
        load_target(1, 16'h8000, 16'h8000);
        load_target(2, 16'h0000, 16'h0000);
        load_target(3, 16'd256, 16'd256);
        load_target(4, 16'd256, 16'd256);
        load_target(5, 16'h8000, 16'h7FFF);
        drain();
        write_reg(CFG_TARGET_COUNT, 16'd1);
        ask(16'h8000, 16'h8000);
        drain();
        write_reg(CFG_TARGET_COUNT, 16'd6);
        ask(16'd256, 16'd256);
        ask(16'd255, 16'd257);
        ask(16'h7FFF, 16'h8000);
        drain();
        write_reg(CFG_ROT_XX, 16'h7FFF);
        write_reg(CFG_ROT_XY, 16'h8000);
        write_reg(CFG_ROT_YX, 16'h8000);
        write_reg(CFG_ROT_YY, 16'h7FFF);
        write_reg(CFG_SHIFT_X, 16'h7FFF);
        write_reg(CFG_SHIFT_Y, 16'h8000);
        write_reg(CFG_SPARE_INDEX, 16'h5A5A);
        ask(16'h7FFF, 16'h8000);
        ask(16'hFFFF, 16'hFFFF);
        drain();
        write_reg(CFG_ROT_XX, 16'd1);
        write_reg(CFG_ROT_XY, 16'd1);
        write_reg(CFG_ROT_YX, 16'hFFFF);
        write_reg(CFG_ROT_YY, 16'hFFFF);
        write_reg(CFG_SHIFT_X, 16'd0);
        write_reg(CFG_SHIFT_Y, 16'd0);
        ask(16'hFFFF, 16'h0000);
        n_settings = 4;

        while (random_items < ITEM_BUDGET)
        begin
            drain();
            if (!big_done && random_items >= ITEM_BUDGET / 2)
            begin
                big_done   = 1'b1;
                coord_span = 3;
                in_quiet   = ($urandom_range(0, 1) == 0);
                for (int s = 0; s < NPM_MAX_POINTS; s++)
                    load_target(s, pick_coord(), pick_coord());
                drain();
                write_reg(CFG_TARGET_COUNT, 16'(NPM_MAX_POINTS));
                ask(pick_coord(), pick_coord());
                ask(pick_coord(), pick_coord());
                drain();
                write_reg(CFG_TARGET_COUNT, 16'(COUNT_ALL_ONES));
                ask(pick_coord(), pick_coord());
                ask(pick_coord(), pick_coord());
                drain();
                write_reg(CFG_TARGET_COUNT, 16'(NPM_MAX_POINTS + 1));
                ask(pick_coord(), pick_coord());
                drain();
                n_settings += 3;
            end

            roll = $urandom_range(0, 9);
            if (roll == 0)
                cur_count = 0;
            else if (roll < 8)
                cur_count = $urandom_range(1, 24);
            else
                cur_count = $urandom_range(25, 96);
            case ($urandom_range(0, 2))
                0:       coord_span = 4;
                1:       coord_span = 256;
                default: coord_span = 8192;
            endcase
            in_quiet  = ($urandom_range(0, 3) == 0);
            out_quiet = ($urandom_range(0, 3) == 0);
            plain     = ($urandom_range(0, 2) == 0);

            write_reg(CFG_ROT_XX, plain ? NPM_ROT_ONE : pick_rot());
            write_reg(CFG_ROT_XY, plain ? 16'h0000 : pick_rot());
            write_reg(CFG_ROT_YX, plain ? 16'h0000 : pick_rot());
            write_reg(CFG_ROT_YY, plain ? NPM_ROT_ONE : pick_rot());
            write_reg(CFG_SHIFT_X, plain ? 16'h0000 : pick_coord());
            write_reg(CFG_SHIFT_Y, plain ? 16'h0000 : pick_coord());
            write_reg(CFG_TARGET_COUNT, 16'(cur_count));
            n_settings++;

            for (int s = 0; s < cur_count; s++)
            begin
                if (!loaded[s])
                begin
                    load_target(s, pick_coord(), pick_coord());
                    random_items++;
                end
            end

            hi_slot   = (cur_count + 16 > NPM_MAX_POINTS - 1) ? NPM_MAX_POINTS - 1
                                                               : cur_count + 16;
            phase_len = $urandom_range(10, 45);
            repeat (phase_len)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    drain();
                if (roll < 45)
                    load_target($urandom_range(0, hi_slot), pick_coord(), pick_coord());
                else
                    ask(pick_coord(), pick_coord());
                random_items++;
            end
        end

        drain();
        repeat (END_CYCLES) @(negedge clk);
        $display("Run covered %0d target loads and %0d queries over %0d register settings,",
                 n_loads, n_queries, n_settings);
        $display("table sizes from empty to the full %0d entries; %0d results compared.",
                 NPM_MAX_POINTS, checked);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### nearest_point_match_2d_core.f
+incdir+sv
sv/npm2d_pkg.sv
sv/npm2d_mem.sv
sv/npm2d_mul.sv
sv/npm2d_seq.sv
sv/nearest_point_match_2d_core.sv
sv/npm2d_chk.sv
bench/npm2d_match_checker.sv
bench/tb_nearest_point_match_2d_core.sv
